// ===== rtl/banded_row_stretch_resampler_unit_defines.svh =====
// Assertion macros used by the banded row stretch resampler checker.
`ifndef BANDED_ROW_STRETCH_RESAMPLER_UNIT_DEFINES_SVH
`define BANDED_ROW_STRETCH_RESAMPLER_UNIT_DEFINES_SVH

// Clocked property, ignored while reset is asserted.
`define BRSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define BRSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/brsr_pkg.sv =====
// Types, constants and helper functions of the banded row stretch resampler.
`timescale 1ns / 1ps

package brsr_pkg;

  // Fixed-point format and limits
  localparam int unsigned FRAC_BITS        = 12;
  localparam int unsigned MAX_SCALE_INT    = 8;
  localparam int unsigned MAX_SOURCE_WIDTH = 4096;

  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned WIDTH_W   = 13;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned ACC_W     = SCALE_W + 1;
  localparam int unsigned WEIGHT_W  = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = WIDTH_W + SCALE_W;
  localparam int unsigned BLEND_W   = FRAC_BITS + 11;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [SCALE_W-1:0] ONE_Q    = SCALE_W'(1 << FRAC_BITS);
  localparam logic [SCALE_W-1:0] SCALE_HI = SCALE_W'(MAX_SCALE_INT << FRAC_BITS);
  localparam logic [WIDTH_W-1:0] WIDTH_HI = WIDTH_W'(MAX_SOURCE_WIDTH);

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_MAX_RST    = 16'd4096;
  localparam logic [WIDTH_W-1:0] SOURCE_WIDTH_RST = 13'd480;

  // Item kind codes
  localparam logic KIND_ROW_START = 1'b0;
  localparam logic KIND_PIXEL     = 1'b1;
  localparam logic OUT_PIXEL      = 1'b0;
  localparam logic OUT_BLACK      = 1'b1;

  // Register index
  typedef enum logic {
    REG_SCALE_MAX    = 1'b0,
    REG_SOURCE_WIDTH = 1'b1
  } reg_idx_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RES_NEXT,
    ST_RES_SELF,
    ST_GEO_MUL1,
    ST_GEO_MUL2,
    ST_GEO_DIV,
    ST_GEO_CNT,
    ST_MARGIN,
    ST_CLOSE
  } ctrl_state_e;

  typedef struct packed {
    logic               kind;
    logic [SCALE_W-1:0] row_scale;
    logic               band_start;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
    logic               row_end;
  } in_item_t;

  typedef struct packed {
    logic               out_kind;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic [7:0]         alpha_out;
    logic [COUNT_W-1:0] run_length;
    logic               row_last;
  } out_item_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_max;
    logic [WIDTH_W-1:0] source_width;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start_row;
    logic take_pixel;
    logic res_step;
    logic res_self;
    logic geo_mul1;
    logic geo_mul2;
    logic geo_div;
    logic geo_cnt;
    logic set_row;
    logic emit_margin;
    logic emit_close;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic held_valid;
    logic quota_done;
    logic active_zero;
    logic res_adv;
    logic margin_nz;
    logic slot_free;
  } dp_status_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    if (v < ONE_Q) begin
      r = ONE_Q;
    end else if (v > SCALE_HI) begin
      r = SCALE_HI;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    if (v == '0) begin
      r = WIDTH_W'(1);
    end else if (v > WIDTH_HI) begin
      r = WIDTH_HI;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/brsr_ctrl.sv =====
// Sequencing state machine of the banded row stretch resampler.
`timescale 1ns / 1ps

module brsr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  brsr_pkg::in_item_t    in_data_i,
  input  brsr_pkg::dp_status_t  status_i,
  output brsr_pkg::dp_cmd_t     cmd_o
);
  import brsr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        row_end_q, row_end_d;
  logic        closing_q, closing_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_end_q <= 1'b0;
      closing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_end_q <= row_end_d;
      closing_q <= closing_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    row_end_d  = row_end_q;
    closing_d  = closing_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_ROW_START) begin
            cmd_o.start_row = 1'b1;
            closing_d       = 1'b0;
            state_d         = ST_GEO_MUL1;
          end else if (!status_i.quota_done) begin
            cmd_o.take_pixel = 1'b1;
            row_end_d        = in_data_i.row_end;
            if (status_i.held_valid) begin
              state_d = ST_RES_NEXT;
            end else if (in_data_i.row_end) begin
              state_d = ST_RES_SELF;
            end
          end
        end
      end
      // Held pixel blended toward the new one
      ST_RES_NEXT: begin
        if (status_i.active_zero) begin
          state_d = row_end_q ? ST_RES_SELF : ST_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.res_step = 1'b1;
          if (status_i.res_adv) begin
            state_d = row_end_q ? ST_RES_SELF : ST_IDLE;
          end
        end
      end
      // Last pixel of the row blended with itself
      ST_RES_SELF: begin
        if (status_i.active_zero) begin
          closing_d = 1'b1;
          state_d   = ST_GEO_MUL1;
        end else if (status_i.slot_free) begin
          cmd_o.res_step = 1'b1;
          cmd_o.res_self = 1'b1;
          if (status_i.res_adv) begin
            closing_d = 1'b1;
            state_d   = ST_GEO_MUL1;
          end
        end
      end
      ST_GEO_MUL1: begin
        cmd_o.geo_mul1 = 1'b1;
        state_d        = ST_GEO_MUL2;
      end
      ST_GEO_MUL2: begin
        cmd_o.geo_mul2 = 1'b1;
        state_d        = ST_GEO_DIV;
      end
      ST_GEO_DIV: begin
        cmd_o.geo_div = 1'b1;
        state_d       = ST_GEO_CNT;
      end
      ST_GEO_CNT: begin
        cmd_o.geo_cnt = 1'b1;
        if (closing_q) begin
          state_d = ST_CLOSE;
        end else begin
          cmd_o.set_row = 1'b1;
          state_d       = status_i.margin_nz ? ST_MARGIN : ST_IDLE;
        end
      end
      ST_MARGIN: begin
        if (status_i.slot_free) begin
          cmd_o.emit_margin = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (status_i.slot_free) begin
          cmd_o.emit_close = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/brsr_dp.sv =====
// Datapath: accumulator, blender, row geometry and output register.
`timescale 1ns / 1ps

module brsr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  brsr_pkg::cfg_t        cfg_i,
  input  brsr_pkg::in_item_t    in_data_i,
  input  brsr_pkg::dp_cmd_t     cmd_i,
  output brsr_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output brsr_pkg::out_item_t   out_data_o
);
  import brsr_pkg::*;

  localparam int unsigned WRAW_W = PROD_W - FRAC_BITS;
  localparam int unsigned LSUM_W = PROD_W - FRAC_BITS + 2;

  // Weighted blend of two bytes, truncated
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [WEIGHT_W-1:0] w);
    logic signed [8:0]         d;
    logic signed [BLEND_W-1:0] prod;
    logic signed [BLEND_W-1:0] sum;
    d    = $signed({1'b0, a}) - $signed({1'b0, b});
    prod = $signed({1'b0, w}) * d;
    sum  = prod + $signed({3'b0, b, {FRAC_BITS{1'b0}}});
    return sum[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // Control state
  logic                 held_valid_q;
  logic                 quota_done_q;
  logic [ACC_W-1:0]     acc_q;
  logic [SCALE_W-1:0]   cur_scale_q;
  logic [COUNT_W-1:0]   active_left_q;
  logic [COUNT_W-1:0]   left_margin_q;
  logic                 out_valid_q;

  // Payload registers
  logic [31:0]          held_q;
  logic [31:0]          new_px_q;
  logic [PROD_W-1:0]    prod_q;
  logic [COUNT_W-1:0]   wout_q;
  logic [COUNT_W-1:0]   l_q;
  logic [COUNT_W-1:0]   m_q;
  logic [COUNT_W-1:0]   n_q;
  out_item_t            out_q;

  logic [WIDTH_W-1:0]   w_eff;
  logic [SCALE_W-1:0]   smax;
  logic [SCALE_W-1:0]   diff;
  logic [SCALE_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [WRAW_W-1:0]    wout_raw;
  logic [LSUM_W-1:0]    lsum;
  logic [WRAW_W-1:0]    l_full;
  logic [COUNT_W-1:0]   k_val;
  logic [COUNT_W-1:0]   n_comb;
  logic signed [COUNT_W+1:0] run_s;
  logic [COUNT_W-1:0]   run_sat;
  logic [31:0]          in_px;
  logic [31:0]          partner;
  logic [ACC_W-1:0]     acc_eff;
  logic [WEIGHT_W-1:0]  w;
  logic [WEIGHT_W-1:0]  rem;
  logic [ACC_W-1:0]     acc_sub;
  logic [ACC_W-1:0]     acc_reload;
  logic                 adv;
  logic                 slot_free;
  logic                 load_out;
  out_item_t            out_d;

  assign in_px = {in_data_i.alpha_in, in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};

  // Geometry: one shared multiplier, then shifts and compares
  assign w_eff    = clamp_width(cfg_i.source_width);
  assign smax     = clamp_scale(cfg_i.scale_max);
  assign diff     = (cur_scale_q < smax) ? (smax - cur_scale_q) : '0;
  assign mul_b    = cmd_i.geo_mul1 ? smax : diff;
  assign mul_p    = {{SCALE_W{1'b0}}, w_eff} * {{WIDTH_W{1'b0}}, mul_b};
  assign wout_raw = prod_q[PROD_W-1:FRAC_BITS];
  assign lsum     = {1'b0, prod_q[PROD_W-1:FRAC_BITS-1]} + LSUM_W'(3);
  assign l_full   = lsum[LSUM_W-1:2];
  assign k_val    = prod_q[PROD_W-1:FRAC_BITS+1];
  assign n_comb   = (m_q > l_q) ? (m_q - l_q) : '0;

  // Closing run: wout - margin - count + unused quota, clamped
  assign run_s   = $signed({2'b0, wout_q}) + $signed({2'b0, active_left_q})
                 - $signed({2'b0, left_margin_q}) - $signed({2'b0, n_q});
  assign run_sat = run_s[COUNT_W+1] ? '0 :
                   (run_s[COUNT_W] ? {COUNT_W{1'b1}} : run_s[COUNT_W-1:0]);

  // Accumulator step
  assign acc_eff    = (acc_q == '0) ? {1'b0, cur_scale_q} : acc_q;
  assign w          = (acc_eff >= {1'b0, ONE_Q}) ? ONE_Q[WEIGHT_W-1:0] : acc_eff[WEIGHT_W-1:0];
  assign rem        = ONE_Q[WEIGHT_W-1:0] - w;
  assign acc_sub    = acc_eff - {{(ACC_W-WEIGHT_W){1'b0}}, w};
  assign adv        = (acc_sub == '0);
  assign acc_reload = {1'b0, cur_scale_q} - {{(ACC_W-WEIGHT_W){1'b0}}, rem};
  assign partner    = cmd_i.res_self ? held_q : new_px_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign load_out  = cmd_i.res_step || cmd_i.emit_margin || cmd_i.emit_close;

  // Result to be loaded
  always_comb begin
    out_d = '0;
    if (cmd_i.res_step) begin
      out_d.out_kind  = OUT_PIXEL;
      out_d.red_out   = blend(held_q[7:0], partner[7:0], w);
      out_d.green_out = blend(held_q[15:8], partner[15:8], w);
      out_d.blue_out  = blend(held_q[23:16], partner[23:16], w);
      out_d.alpha_out = held_q[31:24];
    end else if (cmd_i.emit_margin) begin
      out_d.out_kind   = OUT_BLACK;
      out_d.run_length = left_margin_q;
    end else begin
      out_d.out_kind   = OUT_BLACK;
      out_d.run_length = run_sat;
      out_d.row_last   = 1'b1;
    end
  end

  // Row and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q  <= 1'b0;
      quota_done_q  <= 1'b0;
      acc_q         <= {1'b0, ONE_Q};
      cur_scale_q   <= ONE_Q;
      active_left_q <= '0;
      left_margin_q <= '0;
    end else begin
      if (cmd_i.start_row) begin
        cur_scale_q  <= clamp_scale(in_data_i.row_scale);
        held_valid_q <= 1'b0;
        quota_done_q <= 1'b0;
        if (in_data_i.band_start) begin
          acc_q <= {1'b0, clamp_scale(in_data_i.row_scale)};
        end
      end
      if (cmd_i.take_pixel && !held_valid_q) begin
        held_valid_q <= 1'b1;
      end
      if (cmd_i.res_step) begin
        acc_q         <= adv ? acc_reload : acc_sub;
        active_left_q <= active_left_q - COUNT_W'(1);
      end
      if (cmd_i.set_row) begin
        left_margin_q <= l_q;
        active_left_q <= n_comb;
      end
      if (cmd_i.emit_close) begin
        quota_done_q <= 1'b1;
        held_valid_q <= 1'b0;
      end
    end
  end

  // Pixel and geometry payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pixel) begin
      new_px_q <= in_px;
      if (!held_valid_q) begin
        held_q <= in_px;
      end
    end
    if (cmd_i.res_step && adv && !cmd_i.res_self) begin
      held_q <= new_px_q;
    end
    if (cmd_i.geo_mul1 || cmd_i.geo_mul2) begin
      prod_q <= mul_p;
    end
    if (cmd_i.geo_mul2) begin
      wout_q <= (wout_raw > WRAW_W'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}} : wout_raw[COUNT_W-1:0];
    end
    if (cmd_i.geo_div) begin
      l_q <= (l_full > WRAW_W'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}} : l_full[COUNT_W-1:0];
      m_q <= (wout_q > k_val) ? (wout_q - k_val) : '0;
    end
    if (cmd_i.geo_cnt) begin
      n_q <= n_comb;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.held_valid  = held_valid_q;
  assign status_o.quota_done  = quota_done_q;
  assign status_o.active_zero = (active_left_q == '0);
  assign status_o.res_adv     = adv;
  assign status_o.margin_nz   = (l_q != '0);
  assign status_o.slot_free   = slot_free;

endmodule

// ===== rtl/brsr_regs.sv =====
// APB configuration registers of the banded row stretch resampler.
`timescale 1ns / 1ps

module brsr_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [brsr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [brsr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [brsr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output brsr_pkg::cfg_t                      cfg_o
);
  import brsr_pkg::*;

  logic [SCALE_W-1:0] scale_max_q;
  logic [WIDTH_W-1:0] source_width_q;
  reg_idx_e           idx;
  logic               wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_max_q    <= SCALE_MAX_RST;
      source_width_q <= SOURCE_WIDTH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SCALE_MAX:    scale_max_q    <= pwdata[SCALE_W-1:0];
        REG_SOURCE_WIDTH: source_width_q <= pwdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_SCALE_MAX:    prdata = {{(APB_DATA_W-SCALE_W){1'b0}}, scale_max_q};
      REG_SOURCE_WIDTH: prdata = {{(APB_DATA_W-WIDTH_W){1'b0}}, source_width_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.scale_max    = scale_max_q;
  assign cfg_o.source_width = source_width_q;

endmodule

// ===== rtl/banded_row_stretch_resampler_unit.sv =====
// Top level of the banded row stretch resampler.
//
//   port group   direction  transfer on
//   in_*         input      in_valid_i && in_ready_o  (row start or source pixel)
//   out_*        output     out_valid_o && out_ready_i (image pixel or black run)
//   APB          config     psel && penable && pwrite (pready tied high)
//
// A source pixel is accepted in the idle state and then yields one image pixel
// per cycle while the output slot is free (up to eight per blend pass at scale
// 8.0, up to two passes on a row end); a blend pass stops once the row quota is
// used up. A row start runs the geometry sequence on the shared 13x16 multiplier
// and then its margin run, if any; a row end runs it before the closing run.
// Reset is asynchronous and active low; no clearing pass follows it.
// A stalled output holds the block in its emitting state; one finished result
// may wait in the output register while the next item is accepted.
`timescale 1ns / 1ps

module banded_row_stretch_resampler_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  brsr_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output brsr_pkg::out_item_t              out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [brsr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [brsr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [brsr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import brsr_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers
  brsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer
  brsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  brsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/brsr_checker.sv =====
// Port-level checks of the banded row stretch resampler, bound to the top level.
`timescale 1ns / 1ps
`include "banded_row_stretch_resampler_unit_defines.svh"

module brsr_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input brsr_pkg::in_item_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input brsr_pkg::out_item_t  out_data_o,
  input logic                 pready
);
  import brsr_pkg::*;

  // Stalled result stays put
  `BRSR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // Black runs carry no color
  `BRSR_ASSERT(a_black_zero, clk_i, rst_ni, out_valid_o && (out_data_o.out_kind == OUT_BLACK) |-> (out_data_o.red_out == 8'd0) && (out_data_o.green_out == 8'd0) && (out_data_o.blue_out == 8'd0) && (out_data_o.alpha_out == 8'd0), "black run with color")

  // Image pixels carry no run and never close a row
  `BRSR_ASSERT(a_pixel_clean, clk_i, rst_ni, out_valid_o && (out_data_o.out_kind == OUT_PIXEL) |-> (out_data_o.run_length == '0) && !out_data_o.row_last, "image pixel with run fields")

  // Geometry after a row start keeps the input closed
  `BRSR_ASSERT(a_row_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (in_data_i.kind == KIND_ROW_START) |=> !in_ready_o, "input open during row geometry")

  // Config port never waits
  `BRSR_ASSERT_ALWAYS(a_pready, clk_i, pready, "pready dropped")

endmodule

bind banded_row_stretch_resampler_unit brsr_checker u_brsr_checker (.*);
